@@ sv/salt_pkg.sv @@
// ----------------------------------------------------------------------------
// salt_pkg
// Shared sizes and types of the set-associative tag store with stamp LRU.
// ----------------------------------------------------------------------------
package salt_pkg;

  // The set count must be a power of two: the index is the low address bits.
  localparam int SETS       = 64;
  localparam int WAYS       = 8;
  localparam int STAMP_BITS = 32;
  localparam int TAG_BITS   = 26;
  localparam int CNT_BITS   = 32;

  localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_INSTALL = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

endpackage

@@ sv/salt_row_ram.sv @@
// ----------------------------------------------------------------------------
// salt_row_ram
// One row per set holding every way. Read data is registered; a row that has
// not been written since reset reads back with all ways invalid and clean.
// ----------------------------------------------------------------------------
module salt_row_ram
  import salt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output row_t             rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  row_t             wr_data
);

  row_t            mem [SETS];
  logic [SETS-1:0] row_ok;
  row_t            rd_raw;
  logic            rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_ok[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data = rd_raw;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_ok) begin
        rd_data[w].valid = 1'b0;
        rd_data[w].dirty = 1'b0;
      end
    end
  end

endmodule

@@ sv/salt_lru_tree.sv @@
// ----------------------------------------------------------------------------
// salt_lru_tree
// Finds the way with the oldest stamp, lowest way on ties. The first level of
// pairwise compares is registered; the remaining levels follow in logic.
// ----------------------------------------------------------------------------
module salt_lru_tree
  import salt_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  row_t             row,
  output logic [WAY_W-1:0] way
);

  localparam int NLEAF = 1 << WAY_W;
  localparam int NHALF = NLEAF / 2;

  typedef struct packed {
    logic                  ok;
    logic [WAY_W-1:0]      way;
    logic [STAMP_BITS-1:0] stamp;
  } cand_t;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (b.ok && (!a.ok || (b.stamp < a.stamp))) begin
      return b;
    end
    return a;
  endfunction

  cand_t leaf [NLEAF];
  cand_t half [NHALF];
  cand_t cur  [NHALF];

  for (genvar j = 0; j < NLEAF; j++) begin : g_leaf
    if (j < WAYS) begin : g_real
      assign leaf[j] = '{ok: 1'b1, way: WAY_W'(j), stamp: row[j].stamp};
    end else begin : g_pad
      assign leaf[j] = '{ok: 1'b0, way: WAY_W'(j), stamp: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NHALF; i++) begin
        half[i] <= pick(leaf[2*i], leaf[2*i+1]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NHALF; i++) begin
      cur[i] = half[i];
    end
    for (int lvl = 1; lvl < WAY_W; lvl++) begin
      for (int i = 0; i < (NLEAF >> (lvl + 1)); i++) begin
        cur[i] = pick(cur[2*i], cur[2*i+1]);
      end
    end
    way = cur[0].way;
  end

endmodule

@@ sv/set_assoc_cache_lru_tags.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags
// Tag and state store of a set-associative write-back cache with stamp LRU:
// lookups with hit, dirty marking and counters, installs with victim choice.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: action; tdata: address, write flag, time_stamp
// m_*      out  tdata: hit, victim_way, dirty_evict, evicted_tag,
//               read/write access counts, read/write miss counts, evict count
//
// Each beat passes three steps: accept and row read, tag compare with the
// first LRU level, then the last LRU levels with the row write-back.
// A finished result waits in the output register while the next beat is
// taken in; the write-back stalls only if that register is still full.
// Reset clears the counters and marks every set empty at once.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags
  import salt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // address, write flag, time_stamp
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata    // hit, victim_way, dirty_evict, evicted_tag,
                                  // rd_acc, wr_acc, rd_miss, wr_miss, evictions
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (&v) ? v : v + CNT_BITS'(1);
  endfunction

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic                  accept;
  logic                  commit;

  logic [31:0]           in_addr;
  logic [IDX_W-1:0]      in_idx;

  logic                  it_action;
  logic                  it_write;
  logic [IDX_W-1:0]      it_idx;
  logic [TAG_BITS-1:0]   it_tag;
  logic [STAMP_BITS-1:0] it_stamp;

  row_t                  rd_row;
  row_t                  row;
  row_t                  row_next;
  logic [WAY_W-1:0]      lru_way;

  logic                  hit_any;
  logic [WAY_W-1:0]      hit_sel;
  logic                  free_any;
  logic [WAY_W-1:0]      free_sel;
  logic                  hit_found;
  logic [WAY_W-1:0]      hit_way;
  logic                  free_found;
  logic [WAY_W-1:0]      free_way;

  logic [WAY_W-1:0]      victim;
  logic                  devict;
  logic [TAG_BITS-1:0]   etag;

  logic [CNT_BITS-1:0]   rd_acc;
  logic [CNT_BITS-1:0]   wr_acc;
  logic [CNT_BITS-1:0]   rd_miss;
  logic [CNT_BITS-1:0]   wr_miss;
  logic [CNT_BITS-1:0]   evictions;
  logic [CNT_BITS-1:0]   rd_acc_next;
  logic [CNT_BITS-1:0]   wr_acc_next;
  logic [CNT_BITS-1:0]   rd_miss_next;
  logic [CNT_BITS-1:0]   wr_miss_next;
  logic [CNT_BITS-1:0]   evictions_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_UPD) && (!m_tvalid || m_tready);
  assign in_addr  = s_tdata[31:0];
  assign in_idx   = IDX_W'(in_addr % 32'(SETS));

  salt_row_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_row),
    .wr_en   (commit),
    .wr_addr (it_idx),
    .wr_data (row_next)
  );

  salt_lru_tree u_lru (
    .clk  (clk),
    .load (state == ST_LOOK),
    .row  (rd_row),
    .way  (lru_way)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_action <= s_tuser;
      it_write  <= s_tdata[32];
      it_idx    <= in_idx;
      it_tag    <= TAG_BITS'(in_addr / 32'(SETS));
      it_stamp  <= STAMP_BITS'(s_tdata[64:33]);
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_sel  = '0;
    free_any = 1'b0;
    free_sel = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && (rd_row[w].tag == it_tag)) begin
        hit_any = 1'b1;
        hit_sel = WAY_W'(w);
      end
      if (!rd_row[w].valid) begin
        free_any = 1'b1;
        free_sel = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      row        <= rd_row;
      hit_found  <= hit_any;
      hit_way    <= hit_sel;
      free_found <= free_any;
      free_way   <= free_sel;
    end
  end

  always_comb begin
    victim         = free_found ? free_way : lru_way;
    row_next       = row;
    devict         = 1'b0;
    etag           = '0;
    rd_acc_next    = rd_acc;
    wr_acc_next    = wr_acc;
    rd_miss_next   = rd_miss;
    wr_miss_next   = wr_miss;
    evictions_next = evictions;
    if (it_action == ACT_LOOKUP) begin
      if (it_write) begin
        wr_acc_next = sat_inc(wr_acc);
      end else begin
        rd_acc_next = sat_inc(rd_acc);
      end
      if (hit_found) begin
        row_next[hit_way].stamp = it_stamp;
        if (it_write) begin
          row_next[hit_way].dirty = 1'b1;
        end
      end else if (it_write) begin
        wr_miss_next = sat_inc(wr_miss);
      end else begin
        rd_miss_next = sat_inc(rd_miss);
      end
    end else begin
      if (!free_found && row[victim].dirty) begin
        devict         = 1'b1;
        etag           = row[victim].tag;
        evictions_next = sat_inc(evictions);
      end
      row_next[victim] = '{valid: 1'b1, dirty: 1'b0, tag: it_tag, stamp: it_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_acc    <= '0;
      wr_acc    <= '0;
      rd_miss   <= '0;
      wr_miss   <= '0;
      evictions <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (commit) begin
        rd_acc    <= rd_acc_next;
        wr_acc    <= wr_acc_next;
        rd_miss   <= rd_miss_next;
        wr_miss   <= wr_miss_next;
        evictions <= evictions_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {1'b0, evictions_next, wr_miss_next, rd_miss_next, wr_acc_next,
                  rd_acc_next, etag, devict,
                  (it_action == ACT_LOOKUP) ? 3'd0 : 3'(victim),
                  (it_action == ACT_LOOKUP) && hit_found};
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative tag store with stamp LRU.
// A queue of beats (a directed opening, then random lookups and installs
// aimed at a few busy sets) feeds a driver; a monitor predicts each result
// from its own copy of the tags, flags, stamps and counters and compares the
// output beats field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import salt_pkg::*;

  typedef struct {
    logic        action;
    logic [31:0] addr;
    logic        wr;
    logic [31:0] stamp;
    int          gap;
    bit          drain;
  } access_t;

  typedef struct packed {
    logic                pad;
    logic [31:0]         evict_cnt;
    logic [31:0]         wr_miss_cnt;
    logic [31:0]         rd_miss_cnt;
    logic [31:0]         wr_acc_cnt;
    logic [31:0]         rd_acc_cnt;
    logic [TAG_BITS-1:0] evicted_tag;
    logic                dirty_evict;
    logic [2:0]          victim_way;
    logic                hit;
  } outcome_t;

  localparam int   LINES       = SETS * WAYS;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // address, write flag, time_stamp
  logic         s_tuser = 1'b0; // action
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;        // hit, victim_way, dirty_evict, evicted_tag,
                                // rd_acc, wr_acc, rd_miss, wr_miss, evictions

  set_assoc_cache_lru_tags dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  access_t  pending_beats[$];
  outcome_t expected_results[$];

  logic                  line_valid_q[LINES];
  logic                  line_dirty_q[LINES];
  logic [TAG_BITS-1:0]   line_tag_q[LINES];
  logic [STAMP_BITS-1:0] line_stamp_q[LINES];
  logic [31:0] rd_acc_total, wr_acc_total, rd_miss_total, wr_miss_total, evict_total;

  int in_beats = 0;
  int issued = 0;
  int hold_left = 0;
  int stall_left = 0;
  int sink_cycles = 0;
  int mismatches = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_installs = 0;
  int n_dirty = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] line_at(logic [TAG_BITS-1:0] tg, int unsigned set);
    return 32'(tg) * SETS + set;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  task automatic predict_tag_store(input logic act, input logic [31:0] addr,
                                   input logic wr, input logic [31:0] stamp,
                                   output outcome_t res);
    int base;
    int found;
    int victim;
    logic [TAG_BITS-1:0] tg;
    logic [STAMP_BITS-1:0] oldest;
    res = '0;
    base = int'(addr % SETS) * WAYS;
    tg = TAG_BITS'(addr / SETS);
    if (act == ACT_LOOKUP) begin
      found = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (found < 0 && line_valid_q[base + w] && line_tag_q[base + w] == tg) found = w;
      end
      if (wr) wr_acc_total = sat_inc(wr_acc_total);
      else rd_acc_total = sat_inc(rd_acc_total);
      if (found >= 0) begin
        res.hit = 1'b1;
        if (wr) line_dirty_q[base + found] = 1'b1;
        line_stamp_q[base + found] = stamp;
      end else if (wr) begin
        wr_miss_total = sat_inc(wr_miss_total);
      end else begin
        rd_miss_total = sat_inc(rd_miss_total);
      end
    end else begin
      victim = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (victim < 0 && !line_valid_q[base + w]) victim = w;
      end
      if (victim < 0) begin
        victim = 0;
        oldest = line_stamp_q[base];
        for (int w = 1; w < WAYS; w++) begin
          if (line_stamp_q[base + w] < oldest) begin
            oldest = line_stamp_q[base + w];
            victim = w;
          end
        end
        if (line_dirty_q[base + victim]) begin
          res.dirty_evict = 1'b1;
          res.evicted_tag = line_tag_q[base + victim];
          evict_total = sat_inc(evict_total);
        end
      end
      res.victim_way = 3'(victim);
      line_valid_q[base + victim] = 1'b1;
      line_dirty_q[base + victim] = 1'b0;
      line_stamp_q[base + victim] = stamp;
      line_tag_q[base + victim] = tg;
    end
    res.rd_acc_cnt = rd_acc_total;
    res.wr_acc_cnt = wr_acc_total;
    res.rd_miss_cnt = rd_miss_total;
    res.wr_miss_cnt = wr_miss_total;
    res.evict_cnt = evict_total;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of result %0d: expected %h, got %h",
                 name, n_results, want, got);
    end
  endtask

  task automatic add_beat(input logic act, input logic [31:0] addr, input logic wr,
                          input logic [31:0] stamp, input int gap, input bit drain);
    access_t b;
    b.action = act;
    b.addr = addr;
    b.wr = wr;
    b.stamp = stamp;
    b.gap = gap;
    b.drain = drain;
    pending_beats.push_back(b);
  endtask

  // Monitor: checks result beats and predicts accepted input beats.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(got.hit));
          check_field("victim_way", 64'(want.victim_way), 64'(got.victim_way));
          check_field("dirty_evict", 64'(want.dirty_evict), 64'(got.dirty_evict));
          check_field("evicted_tag", 64'(want.evicted_tag), 64'(got.evicted_tag));
          check_field("read_access_count", 64'(want.rd_acc_cnt), 64'(got.rd_acc_cnt));
          check_field("write_access_count", 64'(want.wr_acc_cnt), 64'(got.wr_acc_cnt));
          check_field("read_miss_count", 64'(want.rd_miss_cnt), 64'(got.rd_miss_cnt));
          check_field("write_miss_count", 64'(want.wr_miss_cnt), 64'(got.wr_miss_cnt));
          check_field("dirty_evict_count", 64'(want.evict_cnt), 64'(got.evict_cnt));
          n_hits += int'(want.hit);
          n_dirty += int'(want.dirty_evict);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_tag_store(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[64:33], want);
        expected_results.push_back(want);
        n_installs += int'(s_tuser == ACT_INSTALL);
        in_beats <= in_beats + 1;
      end
    end
  end

  // Driver: presents queued beats, honoring per-beat gaps and drain points.
  always @(negedge clk) begin
    logic nv;
    access_t nxt;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (nv && in_beats == issued) nv = 1'b0;
      if (!nv) begin
        if (hold_left > 0) begin
          hold_left--;
        end else if (pending_beats.size() != 0 &&
                     (!pending_beats[0].drain || expected_results.size() == 0)) begin
          nxt = pending_beats.pop_front();
          s_tuser <= nxt.action;
          s_tdata <= {7'b0, nxt.stamp, nxt.wr, nxt.addr};
          hold_left = nxt.gap;
          issued++;
          nv = 1'b1;
        end
      end
    end
    s_tvalid <= nv;
  end

  // Result sink with random stalls and stall-free stretches.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      sink_cycles++;
      if ((sink_cycles / 400) % 3 != 0 && $urandom_range(0, 99) < 15)
        stall_left = gap_len();
    end
  end

  initial begin
    int n;
    int unsigned set;
    logic [TAG_BITS-1:0] tg;
    logic [31:0] addr;
    logic [31:0] now;
    logic [31:0] st;
    bit calm;

    for (int i = 0; i < LINES; i++) begin
      line_valid_q[i] = 1'b0;
      line_dirty_q[i] = 1'b0;
      line_tag_q[i] = '0;
      line_stamp_q[i] = '0;
    end
    rd_acc_total = '0;
    wr_acc_total = '0;
    rd_miss_total = '0;
    wr_miss_total = '0;
    evict_total = '0;

    // Directed opening, mostly in set 0.
    add_beat(ACT_LOOKUP, 32'h0, 1'b0, 32'd0, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
    add_beat(ACT_INSTALL, 32'h0, 1'b1, 32'd0, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'h0, 1'b1, 32'd5, 0, 1'b0);
    add_beat(ACT_INSTALL, 32'h0, 1'b0, 32'd6, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'h0, 1'b0, 32'd7, 0, 1'b0);
    add_beat(ACT_INSTALL, line_at('1, 0), 1'b0, 32'd6, 0, 1'b0);
    for (int t = 1; t <= 5; t++)
      add_beat(ACT_INSTALL, line_at(TAG_BITS'(t), 0), 1'b0, 32'd6, 0, 1'b0);
    add_beat(ACT_INSTALL, line_at(TAG_BITS'(9), 0), 1'b0, 32'd100, 0, 1'b1);
    add_beat(ACT_LOOKUP, line_at('1, 0), 1'b1, 32'd3, 0, 1'b0);
    add_beat(ACT_INSTALL, line_at(TAG_BITS'(10), 0), 1'b0, 32'd200, 0, 1'b0);
    add_beat(ACT_LOOKUP, line_at(TAG_BITS'(10), 0), 1'b1, 32'd201, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 0, 1'b0);
    add_beat(ACT_INSTALL, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
    add_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'd0, 0, 1'b0);

    // Random part: a small tag pool in a few busy sets keeps hits and
    // evictions frequent; wide addresses and stamps appear now and then.
    n = 0;
    now = 32'd1000;
    while (n < 1030) begin
      set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 3);
      tg = ($urandom_range(0, 19) == 0) ? TAG_BITS'($urandom) : TAG_BITS'($urandom_range(0, 11));
      addr = ($urandom_range(0, 19) == 0) ? $urandom : line_at(tg, set);
      now = now + $urandom_range(0, 3);
      st = ($urandom_range(0, 49) == 0) ? $urandom : now;
      calm = ((n / 150) % 3) == 2;
      if ($urandom_range(0, 9) < 6) begin
        add_beat(ACT_LOOKUP, addr, 1'($urandom_range(0, 1)), st,
                 (calm || $urandom_range(0, 99) < 55) ? 0 : gap_len(), (n % 200) == 199);
        n++;
        if ($urandom_range(0, 9) < 4) begin
          add_beat(ACT_INSTALL, addr, 1'($urandom_range(0, 1)), st + 1,
                   (calm || $urandom_range(0, 99) < 55) ? 0 : gap_len(), 1'b0);
          n++;
        end
      end else begin
        add_beat(ACT_INSTALL, addr, 1'($urandom_range(0, 1)), st,
                 (calm || $urandom_range(0, 99) < 55) ? 0 : gap_len(), (n % 200) == 199);
        n++;
      end
    end

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (20) @(negedge clk);

    $display("Checked %0d result beats from %0d input beats: %0d hits, %0d installs,",
             n_results, in_beats, n_hits, n_installs);
    $display("%0d dirty evictions, %0d mismatches.", n_dirty, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ set_assoc_cache_lru_tags.f @@
sv/salt_pkg.sv
sv/salt_row_ram.sv
sv/salt_lru_tree.sv
sv/set_assoc_cache_lru_tags.sv
tb/testbench.sv
